FILE: src/touch_pinch_and_swipe_gesture_top_assert.svh
// Assertion macros used by the gesture block checker.
`ifndef TOUCH_PINCH_AND_SWIPE_GESTURE_TOP_ASSERT_SVH
`define TOUCH_PINCH_AND_SWIPE_GESTURE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TPSG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gesture block check failed");

// Next-cycle implication, checked outside reset
`define TPSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gesture block check failed");

// Same-cycle implication, checked during reset too
`define TPSG_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("gesture block check failed");

`endif

FILE: src/tpsg_pkg.sv
// Types, codes and constants of the touch pinch and swipe gesture block.
package tpsg_pkg;

    localparam int COORD_W  = 10;
    localparam int TRAVEL_W = COORD_W + 2;
    localparam int DIST_W   = 2 * COORD_W + 1;
    localparam int SCALED_W = DIST_W + 8;
    localparam int CFG_W    = 21;
    localparam int CFG_IDX_W = 3;

    // Request codes
    localparam logic [1:0] FUNC_SAMPLE     = 2'd0;
    localparam logic [1:0] FUNC_TAKE_STEPS = 2'd1;
    localparam logic [1:0] FUNC_TAKE_SWIPE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_BAND       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DOWN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIDEWAYS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ABORT_UP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ABORT_SIDEWAYS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PINCH_MIN_DIST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT     = 3'd6;

    // Register reset values
    localparam logic [COORD_W-1:0] RST_TOP_BAND       = 10'd64;
    localparam logic [COORD_W-1:0] RST_MIN_DOWN       = 10'd72;
    localparam logic [COORD_W-1:0] RST_MAX_SIDEWAYS   = 10'd120;
    localparam logic [COORD_W-1:0] RST_ABORT_UP       = 10'd24;
    localparam logic [COORD_W-1:0] RST_ABORT_SIDEWAYS = 10'd140;
    localparam logic [DIST_W-1:0]  RST_PINCH_MIN_DIST = 21'd400;
    localparam logic [2:0]         RST_STEP_LIMIT     = 3'd4;

    // Pinch ratio 1.44 as 144 / 100
    localparam logic [7:0] RATIO_NUM = 8'd144;
    localparam logic [7:0] RATIO_DEN = 8'd100;

    typedef struct packed {
        logic [1:0]         func;
        logic [2:0]         finger_count;
        logic [COORD_W-1:0] raw_x0;
        logic [COORD_W-1:0] raw_y0;
        logic [COORD_W-1:0] raw_x1;
        logic [COORD_W-1:0] raw_y1;
        logic [COORD_W-1:0] disp_x0;
        logic [COORD_W-1:0] disp_y0;
        logic [COORD_W-1:0] disp_x1;
        logic [COORD_W-1:0] disp_y1;
    } t_in;

    typedef struct packed {
        logic               pressed;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               gesture_active;
        logic signed [3:0]  pinch_steps;
        logic               swipe_pending;
    } t_out;

    typedef struct packed {
        logic [COORD_W-1:0] swipe_top_band;
        logic [COORD_W-1:0] swipe_min_down;
        logic [COORD_W-1:0] swipe_max_sideways;
        logic [COORD_W-1:0] swipe_abort_up;
        logic [COORD_W-1:0] swipe_abort_sideways;
        logic [DIST_W-1:0]  pinch_min_dist_sq;
        logic [2:0]         pinch_step_limit;
    } t_cfg;

endpackage

FILE: src/touch_pinch_and_swipe_gesture_top.sv
// Top level of the touch pinch and swipe gesture block.
// Takes one request per clock while the input is not stalled and returns exactly one
// result per request: the input register computes the squared raw finger distance
// (two 10-bit squares and an add), and from there the core runs the swipe travel
// compares, the 1.44 pinch ratio compare (constant scaling by 100 and 144) and the
// state update into the result register. Func 0 is a touch sample, func 1 reads and
// clears the pinch steps, func 2 reads and clears the swipe flag, func 3 returns
// status only. Input stall rises only while a result waits and the next one is
// already held. The user writes the registers through the plain write port only
// while no request is in flight; the block itself does not enforce this.
module touch_pinch_and_swipe_gesture_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tpsg_pkg::t_in                  i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tpsg_pkg::t_out                 o_out,
    input  logic                           i_cfg_we,
    input  logic [tpsg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tpsg_pkg::CFG_W-1:0]     i_cfg_data
);

    tpsg_pkg::t_cfg                cfg;
    tpsg_pkg::t_in                 item;
    logic [tpsg_pkg::DIST_W-1:0]   d2;
    logic                          item_vld;
    logic                          core_ready;

    tpsg_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tpsg_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_ready    (core_ready),
        .o_vld      (item_vld),
        .o_item     (item),
        .o_d2       (d2)
    );

    tpsg_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (item_vld),
        .i_item      (item),
        .i_d2        (d2),
        .i_cfg       (cfg),
        .i_out_stall (i_out_stall),
        .o_ready     (core_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

FILE: src/tpsg_cfg_regs.sv
// Configuration register bank of the gesture block.
module tpsg_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tpsg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tpsg_pkg::CFG_W-1:0]     i_cfg_data,
    output tpsg_pkg::t_cfg                 o_cfg
);

    tpsg_pkg::t_cfg r_cfg;
    tpsg_pkg::t_cfg n_cfg;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                tpsg_pkg::CFG_TOP_BAND:
                    n_cfg.swipe_top_band = i_cfg_data[tpsg_pkg::COORD_W-1:0];
                tpsg_pkg::CFG_MIN_DOWN:
                    n_cfg.swipe_min_down = i_cfg_data[tpsg_pkg::COORD_W-1:0];
                tpsg_pkg::CFG_MAX_SIDEWAYS:
                    n_cfg.swipe_max_sideways = i_cfg_data[tpsg_pkg::COORD_W-1:0];
                tpsg_pkg::CFG_ABORT_UP:
                    n_cfg.swipe_abort_up = i_cfg_data[tpsg_pkg::COORD_W-1:0];
                tpsg_pkg::CFG_ABORT_SIDEWAYS:
                    n_cfg.swipe_abort_sideways = i_cfg_data[tpsg_pkg::COORD_W-1:0];
                tpsg_pkg::CFG_PINCH_MIN_DIST:
                    n_cfg.pinch_min_dist_sq = i_cfg_data[tpsg_pkg::DIST_W-1:0];
                tpsg_pkg::CFG_STEP_LIMIT:
                    n_cfg.pinch_step_limit = i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.swipe_top_band       <= tpsg_pkg::RST_TOP_BAND;
            r_cfg.swipe_min_down       <= tpsg_pkg::RST_MIN_DOWN;
            r_cfg.swipe_max_sideways   <= tpsg_pkg::RST_MAX_SIDEWAYS;
            r_cfg.swipe_abort_up       <= tpsg_pkg::RST_ABORT_UP;
            r_cfg.swipe_abort_sideways <= tpsg_pkg::RST_ABORT_SIDEWAYS;
            r_cfg.pinch_min_dist_sq    <= tpsg_pkg::RST_PINCH_MIN_DIST;
            r_cfg.pinch_step_limit     <= tpsg_pkg::RST_STEP_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/tpsg_in_stage.sv
// Input register: holds the request and its squared raw finger distance.
module tpsg_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  tpsg_pkg::t_in               i_in,
    input  logic                        i_ready,
    output logic                        o_vld,
    output tpsg_pkg::t_in               o_item,
    output logic [tpsg_pkg::DIST_W-1:0] o_d2
);

    localparam int SQW = 2 * tpsg_pkg::COORD_W;

    logic                          r_vld;
    tpsg_pkg::t_in                 r_item;
    logic [tpsg_pkg::DIST_W-1:0]   r_d2;
    logic [tpsg_pkg::COORD_W-1:0]  adx;
    logic [tpsg_pkg::COORD_W-1:0]  ady;
    logic [SQW-1:0]                sqx;
    logic [SQW-1:0]                sqy;
    logic [tpsg_pkg::DIST_W-1:0]   n_d2;
    logic                          accept;
    logic                          advance;

    // Squared raw distance from absolute differences
    always_comb begin
        adx = (i_in.raw_x0 >= i_in.raw_x1) ? (i_in.raw_x0 - i_in.raw_x1)
                                           : (i_in.raw_x1 - i_in.raw_x0);
        ady = (i_in.raw_y0 >= i_in.raw_y1) ? (i_in.raw_y0 - i_in.raw_y1)
                                           : (i_in.raw_y1 - i_in.raw_y0);
        sqx = SQW'(adx) * SQW'(adx);
        sqy = SQW'(ady) * SQW'(ady);
        n_d2 = {1'b0, sqx} + {1'b0, sqy};
    end

    // Stall only while a held request cannot move on
    assign advance    = r_vld && i_ready;
    assign o_in_stall = r_vld && !i_ready;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (advance) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
            r_d2   <= n_d2;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;
    assign o_d2   = r_d2;

endmodule

FILE: src/tpsg_core.sv
// Gesture state, single-pass update and result register.
module tpsg_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  tpsg_pkg::t_in               i_item,
    input  logic [tpsg_pkg::DIST_W-1:0] i_d2,
    input  tpsg_pkg::t_cfg              i_cfg,
    input  logic                        i_out_stall,
    output logic                        o_ready,
    output logic                        o_out_valid,
    output tpsg_pkg::t_out              o_out
);

    localparam int CW = tpsg_pkg::COORD_W;
    localparam int TW = tpsg_pkg::TRAVEL_W;
    localparam int DW = tpsg_pkg::DIST_W;
    localparam int SW = tpsg_pkg::SCALED_W;

    // Gesture state
    logic                 r_trk,  n_trk;
    logic                 r_lat,  n_lat;
    logic                 r_flag, n_flag;
    logic [CW-1:0]        r_sx,   n_sx;
    logic [CW-1:0]        r_sy,   n_sy;
    logic                 r_pact, n_pact;
    logic [DW-1:0]        r_pref, n_pref;
    logic signed [3:0]    r_step, n_step;

    // Result register
    logic                 r_out_vld;
    tpsg_pkg::t_out       r_out;
    tpsg_pkg::t_out       n_res;

    logic                 fire;
    logic                 two;
    logic [CW:0]          sum_x, sum_y;
    logic [CW-1:0]        cx, cy;
    logic signed [TW-1:0] tx, ty;
    logic signed [TW-1:0] min_down, max_side, abort_up, abort_side;
    logic                 in_band, swipe_ok, swipe_abort;
    logic [SW-1:0]        d2_x100, d2_x144, ref_x100, ref_x144;
    logic                 zoom_in, zoom_out;
    logic signed [4:0]    lim, step_next, step_sat;
    logic                 gest;

    assign o_ready = !r_out_vld || !i_out_stall;
    assign fire    = i_vld && o_ready;

    // Swipe centre and travel
    always_comb begin
        two   = (i_item.finger_count >= 3'd2);
        sum_x = {1'b0, i_item.disp_x0} + {1'b0, i_item.disp_x1};
        sum_y = {1'b0, i_item.disp_y0} + {1'b0, i_item.disp_y1};
        cx    = sum_x[CW:1];
        cy    = sum_y[CW:1];
        tx    = $signed({2'b00, cx}) - $signed({2'b00, r_sx});
        ty    = $signed({2'b00, cy}) - $signed({2'b00, r_sy});
        min_down   = $signed({2'b00, i_cfg.swipe_min_down});
        max_side   = $signed({2'b00, i_cfg.swipe_max_sideways});
        abort_up   = $signed({2'b00, i_cfg.swipe_abort_up});
        abort_side = $signed({2'b00, i_cfg.swipe_abort_sideways});
        in_band    = (i_item.disp_y0 <= i_cfg.swipe_top_band) &&
                     (i_item.disp_y1 <= i_cfg.swipe_top_band);
        swipe_ok   = (ty >= min_down) && (tx >= -max_side) && (tx <= max_side);
        swipe_abort = (ty < -abort_up) || (tx < -abort_side) || (tx > abort_side);
    end

    // Pinch ratio compare and saturated step
    always_comb begin
        d2_x100  = SW'(i_d2)   * SW'(tpsg_pkg::RATIO_DEN);
        d2_x144  = SW'(i_d2)   * SW'(tpsg_pkg::RATIO_NUM);
        ref_x100 = SW'(r_pref) * SW'(tpsg_pkg::RATIO_DEN);
        ref_x144 = SW'(r_pref) * SW'(tpsg_pkg::RATIO_NUM);
        zoom_in  = (d2_x100 >= ref_x144);
        zoom_out = (d2_x144 <= ref_x100);
        lim      = $signed({2'b00, i_cfg.pinch_step_limit});
        step_next = zoom_in ? ({r_step[3], r_step} + 5'sd1)
                            : ({r_step[3], r_step} - 5'sd1);
        if (step_next > lim) begin
            step_sat = lim;
        end else if (step_next < -lim) begin
            step_sat = -lim;
        end else begin
            step_sat = step_next;
        end
    end

    // Next state and result for one request
    always_comb begin
        n_trk  = r_trk;
        n_lat  = r_lat;
        n_flag = r_flag;
        n_sx   = r_sx;
        n_sy   = r_sy;
        n_pact = r_pact;
        n_pref = r_pref;
        n_step = r_step;
        gest   = r_trk || r_lat;
        n_res  = '0;
        case (i_item.func)
            tpsg_pkg::FUNC_SAMPLE: begin
                // Swipe tracking
                if (!two) begin
                    n_trk = 1'b0;
                    n_lat = 1'b0;
                    gest  = 1'b0;
                end else if (r_lat) begin
                    gest = 1'b1;
                end else if (!r_trk) begin
                    gest = in_band;
                    if (in_band) begin
                        n_trk = 1'b1;
                        n_sx  = cx;
                        n_sy  = cy;
                    end
                end else if (swipe_ok) begin
                    n_flag = 1'b1;
                    n_trk  = 1'b0;
                    n_lat  = 1'b1;
                    n_step = '0;
                    gest   = 1'b1;
                end else if (swipe_abort) begin
                    n_trk = 1'b0;
                    gest  = 1'b0;
                end else begin
                    gest = 1'b1;
                end
                // Pinch tracking, held off by any swipe
                if (gest || !two) begin
                    n_pact = 1'b0;
                    n_pref = '0;
                end else if (!r_pact) begin
                    if (i_d2 >= i_cfg.pinch_min_dist_sq) begin
                        n_pref = i_d2;
                        n_pact = 1'b1;
                    end
                end else if (zoom_in || zoom_out) begin
                    n_step = step_sat[3:0];
                    n_pref = i_d2;
                end
                if (i_item.finger_count != 3'd0) begin
                    n_res.pressed = 1'b1;
                    n_res.point_x = i_item.raw_x0;
                    n_res.point_y = i_item.raw_y0;
                end
                n_res.pinch_steps   = n_step;
                n_res.swipe_pending = n_flag;
            end
            tpsg_pkg::FUNC_TAKE_STEPS: begin
                n_res.pinch_steps   = r_step;
                n_res.swipe_pending = r_flag;
                n_step              = '0;
            end
            tpsg_pkg::FUNC_TAKE_SWIPE: begin
                n_res.pinch_steps   = r_step;
                n_res.swipe_pending = r_flag;
                n_flag              = 1'b0;
            end
            default: begin
                n_res.pinch_steps   = r_step;
                n_res.swipe_pending = r_flag;
            end
        endcase
        n_res.gesture_active = gest;
    end

    // Commit state on each request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trk  <= 1'b0;
            r_lat  <= 1'b0;
            r_flag <= 1'b0;
            r_sx   <= '0;
            r_sy   <= '0;
            r_pact <= 1'b0;
            r_pref <= '0;
            r_step <= '0;
        end else if (fire) begin
            r_trk  <= n_trk;
            r_lat  <= n_lat;
            r_flag <= n_flag;
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_pact <= n_pact;
            r_pref <= n_pref;
            r_step <= n_step;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

FILE: src/tpsg_checker.sv
// Port-level checker for the gesture block, bound to the top level.
`include "touch_pinch_and_swipe_gesture_top_assert.svh"

module tpsg_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_stall,
    input logic           i_out_valid,
    input logic           i_out_stall,
    input tpsg_pkg::t_out i_out
);

    // A stalled result stays offered
    `TPSG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid)
    // A stalled result does not change
    `TPSG_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && i_out_stall, $stable(i_out))
    // Input backs up only behind a stalled result
    `TPSG_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, i_in_stall, i_out_valid && i_out_stall)
    // Reset leaves both channels empty
    `TPSG_ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n), !i_out_valid && !i_in_stall)

endmodule

bind touch_pinch_and_swipe_gesture_top tpsg_checker u_tpsg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);

FILE: tb/tb_top.sv
// Testbench of the touch pinch and swipe gesture block: scoreboard, stimulus and checking.
`timescale 1ns / 1ps

// Predicts the status of every accepted request and checks results in order
class gesture_checker;
    tpsg_pkg::t_cfg cfg;
    bit     tracking;
    bit     latched;
    bit     flag;
    bit     pinch_on;
    int     start_x;
    int     start_y;
    longint pinch_ref;
    int     step_count;
    tpsg_pkg::t_out status_due[$];
    int     errors;

    function new();
        cfg.swipe_top_band       = tpsg_pkg::RST_TOP_BAND;
        cfg.swipe_min_down       = tpsg_pkg::RST_MIN_DOWN;
        cfg.swipe_max_sideways   = tpsg_pkg::RST_MAX_SIDEWAYS;
        cfg.swipe_abort_up       = tpsg_pkg::RST_ABORT_UP;
        cfg.swipe_abort_sideways = tpsg_pkg::RST_ABORT_SIDEWAYS;
        cfg.pinch_min_dist_sq    = tpsg_pkg::RST_PINCH_MIN_DIST;
        cfg.pinch_step_limit     = tpsg_pkg::RST_STEP_LIMIT;
        tracking   = 0;
        latched    = 0;
        flag       = 0;
        pinch_on   = 0;
        start_x    = 0;
        start_y    = 0;
        pinch_ref  = 0;
        step_count = 0;
        errors     = 0;
    endfunction

    // Mirror a register write; unused indexes change nothing
    function void apply_reg(logic [tpsg_pkg::CFG_IDX_W-1:0] idx,
                            logic [tpsg_pkg::CFG_W-1:0] data);
        case (idx)
            tpsg_pkg::CFG_TOP_BAND:
                cfg.swipe_top_band       = data[tpsg_pkg::COORD_W-1:0];
            tpsg_pkg::CFG_MIN_DOWN:
                cfg.swipe_min_down       = data[tpsg_pkg::COORD_W-1:0];
            tpsg_pkg::CFG_MAX_SIDEWAYS:
                cfg.swipe_max_sideways   = data[tpsg_pkg::COORD_W-1:0];
            tpsg_pkg::CFG_ABORT_UP:
                cfg.swipe_abort_up       = data[tpsg_pkg::COORD_W-1:0];
            tpsg_pkg::CFG_ABORT_SIDEWAYS:
                cfg.swipe_abort_sideways = data[tpsg_pkg::COORD_W-1:0];
            tpsg_pkg::CFG_PINCH_MIN_DIST:
                cfg.pinch_min_dist_sq    = data[tpsg_pkg::DIST_W-1:0];
            tpsg_pkg::CFG_STEP_LIMIT:
                cfg.pinch_step_limit     = data[2:0];
            default: ;
        endcase
    endfunction

    // Advance swipe tracking; return whether a swipe is tracked or latched
    function bit update_swipe(tpsg_pkg::t_in r);
        int cx, cy, tx, ty, band, mdown, side, up, abort_side, y0, y1;
        if (r.finger_count < 2) begin
            tracking = 0;
            latched  = 0;
            return 0;
        end
        cx = (r.disp_x0 + r.disp_x1) >> 1;
        cy = (r.disp_y0 + r.disp_y1) >> 1;
        if (latched)
            return 1;
        band = cfg.swipe_top_band;
        y0   = r.disp_y0;
        y1   = r.disp_y1;
        if (!tracking) begin
            if (y0 <= band && y1 <= band) begin
                tracking = 1;
                start_x  = cx;
                start_y  = cy;
            end
            return tracking;
        end
        mdown      = cfg.swipe_min_down;
        side       = cfg.swipe_max_sideways;
        up         = cfg.swipe_abort_up;
        abort_side = cfg.swipe_abort_sideways;
        ty = cy - start_y;
        tx = cx - start_x;
        if (ty >= mdown && tx >= -side && tx <= side) begin
            flag       = 1;
            tracking   = 0;
            latched    = 1;
            step_count = 0;
        end else if (ty < -up || tx < -abort_side || tx > abort_side) begin
            tracking = 0;
        end
        return tracking || latched;
    endfunction

    // Compare the squared raw distance with the reference and move the counter
    function void track_pinch(tpsg_pkg::t_in r);
        longint a, b, ddx, ddy, d2, mind;
        int stepv, nxt, lim;
        if (r.finger_count < 2) begin
            pinch_on  = 0;
            pinch_ref = 0;
            return;
        end
        a = r.raw_x0;
        b = r.raw_x1;
        ddx = a - b;
        a = r.raw_y0;
        b = r.raw_y1;
        ddy = a - b;
        d2 = ddx * ddx + ddy * ddy;
        if (!pinch_on) begin
            mind = cfg.pinch_min_dist_sq;
            if (d2 >= mind) begin
                pinch_ref = d2;
                pinch_on  = 1;
            end
            return;
        end
        stepv = 0;
        if (d2 * 100 >= pinch_ref * 144)
            stepv = 1;
        else if (d2 * 144 <= pinch_ref * 100)
            stepv = -1;
        if (stepv == 0)
            return;
        lim = cfg.pinch_step_limit;
        nxt = step_count + stepv;
        if (nxt > lim)
            nxt = lim;
        else if (nxt < -lim)
            nxt = -lim;
        step_count = nxt;
        pinch_ref  = d2;
    endfunction

    // Work out the status of an accepted request and queue it
    function void note_request(tpsg_pkg::t_in r);
        tpsg_pkg::t_out want;
        bit gest;
        want = '0;
        if (r.func == tpsg_pkg::FUNC_SAMPLE) begin
            gest = update_swipe(r);
            if (gest) begin
                pinch_on  = 0;
                pinch_ref = 0;
            end else begin
                track_pinch(r);
            end
            if (r.finger_count != 0) begin
                want.pressed = 1'b1;
                want.point_x = r.raw_x0;
                want.point_y = r.raw_y0;
            end
            want.pinch_steps   = 4'(step_count);
            want.swipe_pending = flag;
        end else begin
            gest = tracking || latched;
            want.pinch_steps   = 4'(step_count);
            want.swipe_pending = flag;
            if (r.func == tpsg_pkg::FUNC_TAKE_STEPS)
                step_count = 0;
            else if (r.func == tpsg_pkg::FUNC_TAKE_SWIPE)
                flag = 0;
        end
        want.gesture_active = gest;
        status_due.push_back(want);
    endfunction

    function void check_field(string name, logic signed [10:0] want_v,
                              logic signed [10:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            errors++;
        end
    endfunction

    // Compare a result with the oldest queued status
    function void check_status(tpsg_pkg::t_out got);
        tpsg_pkg::t_out want;
        if (status_due.size() == 0) begin
            $error("result with no request waiting");
            errors++;
            return;
        end
        want = status_due.pop_front();
        check_field("pressed", {10'd0, want.pressed}, {10'd0, got.pressed});
        check_field("point_x", {1'b0, want.point_x}, {1'b0, got.point_x});
        check_field("point_y", {1'b0, want.point_y}, {1'b0, got.point_y});
        check_field("gesture_active", {10'd0, want.gesture_active},
                    {10'd0, got.gesture_active});
        check_field("pinch_steps", want.pinch_steps, got.pinch_steps);
        check_field("swipe_pending", {10'd0, want.swipe_pending},
                    {10'd0, got.swipe_pending});
    endfunction

    function int pending();
        return status_due.size();
    endfunction
endclass

module tb_top;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int CW              = tpsg_pkg::COORD_W;
    localparam int RW              = tpsg_pkg::CFG_W;
    localparam logic [tpsg_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               o_in_stall;
    tpsg_pkg::t_in                      in_req;
    logic                               o_out_valid;
    logic                               out_stall = 1'b0;
    tpsg_pkg::t_out                     o_out;
    logic                               cfg_we;
    logic [tpsg_pkg::CFG_IDX_W-1:0]     cfg_idx;
    logic [RW-1:0]                      cfg_data;

    gesture_checker sb;
    int sent_count  = 0;
    int quiet_count = 0;
    int stall_left  = 0;
    int in_mode     = 1;
    int out_mode    = 1;
    int in_modes[NUM_PHASES]  = '{0, 1, 2, 1, 0, 2, 1};
    int out_modes[NUM_PHASES] = '{0, 1, 2, 0, 1, 1, 2};

    touch_pinch_and_swipe_gesture_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out      (o_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Mostly short gaps, a few long ones; mode 0 means none
    function automatic int idle_length(int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (mode == 1) begin
            if (r < 70) return 0;
            if (r < 95) return $urandom_range(1, 3);
            return $urandom_range(6, 20);
        end
        if (r < 40) return 0;
        if (r < 80) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0) return 0;
        if (v > 1023) return 1023;
        return v;
    endfunction

    function automatic int rand_coord();
        return $urandom_range(0, 1023);
    endfunction

    function automatic int pick_count();
        if ($urandom_range(0, 99) < 80)
            return 2;
        return $urandom_range(3, 7);
    endfunction

    function automatic tpsg_pkg::t_in make_sample(logic [1:0] func, int cnt, int rx0,
                                                  int ry0, int rx1, int ry1, int dx0,
                                                  int dy0, int dx1, int dy1);
        tpsg_pkg::t_in r;
        r.func          = func;
        r.finger_count  = 3'(cnt);
        r.raw_x0        = CW'(rx0);
        r.raw_y0        = CW'(ry0);
        r.raw_x1        = CW'(rx1);
        r.raw_y1        = CW'(ry1);
        r.disp_x0       = CW'(dx0);
        r.disp_y0       = CW'(dy0);
        r.disp_x1       = CW'(dx1);
        r.disp_y1       = CW'(dy1);
        return r;
    endfunction

    function automatic tpsg_pkg::t_in noise_request();
        return make_sample(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic tpsg_pkg::t_cfg random_cfg();
        tpsg_pkg::t_cfg c;
        c.swipe_top_band       = $urandom_range(0, 300);
        c.swipe_min_down       = $urandom_range(0, 200);
        c.swipe_max_sideways   = $urandom_range(0, 300);
        c.swipe_abort_up       = $urandom_range(0, 100);
        c.swipe_abort_sideways = $urandom_range(0, 400);
        if ($urandom_range(0, 3) == 0)
            c.pinch_min_dist_sq = $urandom_range(0, 2097151);
        else
            c.pinch_min_dist_sq = $urandom_range(0, 40000);
        c.pinch_step_limit = $urandom_range(0, 7);
        return c;
    endfunction

    // Present one request; called and left just after a falling edge
    task automatic send_request(input tpsg_pkg::t_in req);
        int gap;
        gap = idle_length(in_mode);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        sb.note_request(req);
        sent_count++;
        @(negedge clk);
    endtask

    // Hold off the sender until every result is back, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [tpsg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [RW-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        sb.apply_reg(idx, data);
        @(negedge clk);
    endtask

    // Write every register; unused upper data bits carry noise
    task automatic program_regs(input tpsg_pkg::t_cfg c);
        put_reg(tpsg_pkg::CFG_TOP_BAND,       {11'($urandom), c.swipe_top_band});
        put_reg(tpsg_pkg::CFG_MIN_DOWN,       {11'($urandom), c.swipe_min_down});
        put_reg(tpsg_pkg::CFG_MAX_SIDEWAYS,   {11'($urandom), c.swipe_max_sideways});
        put_reg(tpsg_pkg::CFG_ABORT_UP,       {11'($urandom), c.swipe_abort_up});
        put_reg(tpsg_pkg::CFG_ABORT_SIDEWAYS, {11'($urandom), c.swipe_abort_sideways});
        put_reg(tpsg_pkg::CFG_PINCH_MIN_DIST, c.pinch_min_dist_sq);
        put_reg(tpsg_pkg::CFG_STEP_LIMIT,     {18'($urandom), c.pinch_step_limit});
        put_reg(CFG_SPARE,                    RW'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Two or more fingers starting in the top band, then moving by random travel
    task automatic swipe_sequence();
        int band, mdown, side, up, cnt, sx0, sy0, sx1, sy1, moves, ox, oy;
        band  = sb.cfg.swipe_top_band;
        mdown = sb.cfg.swipe_min_down;
        side  = sb.cfg.swipe_max_sideways;
        up    = sb.cfg.swipe_abort_up;
        cnt   = pick_count();
        sx0   = rand_coord();
        sx1   = rand_coord();
        sy0   = $urandom_range(0, band);
        sy1   = $urandom_range(0, band);
        if ($urandom_range(0, 9) == 0)
            sy1 = clamp_coord(band + 1);
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, cnt, rand_coord(), rand_coord(),
                                 rand_coord(), rand_coord(), sx0, sy0, sx1, sy1));
        moves = $urandom_range(1, 5);
        for (int i = 0; i < moves; i++) begin
            oy = $urandom_range(0, 2 * mdown + 20);
            if ($urandom_range(0, 3) == 0)
                oy = oy - up - 30;
            ox = $urandom_range(0, 2 * side + 60);
            ox = ox - side - 30;
            send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, cnt, rand_coord(), rand_coord(),
                                     rand_coord(), rand_coord(), clamp_coord(sx0 + ox),
                                     clamp_coord(sy0 + oy), clamp_coord(sx1 + ox),
                                     clamp_coord(sy1 + oy)));
        end
        if ($urandom_range(0, 1) == 0)
            send_request(make_sample(tpsg_pkg::FUNC_TAKE_SWIPE, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, $urandom_range(0, 1), rand_coord(),
                                 rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                 rand_coord(), rand_coord(), rand_coord()));
    endtask

    // Two or more fingers below the band whose raw distance grows and shrinks
    task automatic pinch_sequence();
        int band, cnt, d, x0, y0, dy0, dy1, moves, pct;
        band = sb.cfg.swipe_top_band;
        cnt  = pick_count();
        if (band < 1023) begin
            dy0 = $urandom_range(band + 1, 1023);
            dy1 = $urandom_range(band + 1, 1023);
        end else begin
            dy0 = rand_coord();
            dy1 = rand_coord();
        end
        d     = $urandom_range(0, 700);
        x0    = $urandom_range(0, 1023 - d);
        y0    = rand_coord();
        moves = $urandom_range(2, 12);
        for (int i = 0; i < moves; i++) begin
            send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, cnt, x0, y0, x0 + d,
                                     clamp_coord(y0 + $urandom_range(0, d / 4)),
                                     rand_coord(), dy0, rand_coord(), dy1));
            if ($urandom_range(0, 7) == 0)
                send_request(make_sample(tpsg_pkg::FUNC_TAKE_STEPS, $urandom, $urandom,
                                         $urandom, $urandom, $urandom, $urandom, $urandom,
                                         $urandom, $urandom));
            pct = $urandom_range(65, 140);
            d   = d * pct / 100;
            if (d < 4 && $urandom_range(0, 1) == 0)
                d = $urandom_range(0, 20);
            if (d > 1023)
                d = 1023;
            if (x0 + d > 1023)
                x0 = 1023 - d;
        end
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, $urandom_range(0, 1), rand_coord(),
                                 rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                 rand_coord(), rand_coord(), rand_coord()));
    endtask

    task automatic random_burst();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            swipe_sequence();
        end else if (r < 70) begin
            pinch_sequence();
        end else if (r < 85) begin
            send_request(make_sample(2'($urandom_range(1, 3)), $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom));
        end else begin
            repeat ($urandom_range(1, 3)) send_request(noise_request());
        end
    endtask

    // Check each accepted result
    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall)
            sb.check_status(o_out);
    end

    // Drive the output stall in runs of random length
    always @(negedge clk) begin
        int len;
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            len = idle_length(out_mode);
            if (len > 0) begin
                out_stall  <= 1'b1;
                stall_left = len - 1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        tpsg_pkg::t_cfg c;
        sb       = new();
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_req   = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings
        // released sample with all-ones coordinates, then one finger
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 0, 1023, 1023, 1023, 1023,
                                 1023, 1023, 1023, 1023));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 1, 1023, 1023, 0, 0, 0, 0, 0, 0));
        // swipe from the top band, accepted, held, then taken
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 0, 0, 0, 0, 500, 10, 600, 20));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 0, 0, 0, 0, 520, 95, 620, 105));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 0, 0, 0, 0, 520, 95, 620, 105));
        send_request(make_sample(tpsg_pkg::FUNC_TAKE_SWIPE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // unused selector with all other bits set
        send_request(make_sample(2'b11, 7, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // pinch start, zoom in up to saturation, zoom out, dead zone
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 100, 500, 200, 500,
                                 300, 600, 400, 600));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 100, 500, 230, 500,
                                 300, 600, 400, 600));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 100, 500, 260, 500,
                                 300, 600, 400, 600));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 100, 500, 300, 500,
                                 300, 600, 400, 600));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 100, 500, 350, 500,
                                 300, 600, 400, 600));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 100, 500, 420, 500,
                                 300, 600, 400, 600));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 100, 500, 300, 500,
                                 300, 600, 400, 600));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 100, 500, 305, 500,
                                 300, 600, 400, 600));
        send_request(make_sample(tpsg_pkg::FUNC_TAKE_STEPS, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // finger counts above two and the largest distance
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 7, 0, 0, 1023, 1023,
                                 1023, 1023, 0, 1023));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 6, 1023, 1023, 0, 0,
                                 0, 1023, 1023, 1023));
        // swipe abandoned by upward travel, then by sideways travel
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 0, 0, 0, 0, 500, 60, 500, 60));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 0, 0, 0, 0, 500, 30, 500, 30));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 0, 0, 0, 0, 500, 10, 500, 10));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 2, 0, 0, 0, 0, 700, 20, 700, 20));
        send_request(make_sample(tpsg_pkg::FUNC_TAKE_STEPS, 7, 1023, 1023, 1023, 1023,
                                 1023, 1023, 1023, 1023));
        send_request(make_sample(tpsg_pkg::FUNC_SAMPLE, 1, 0, 0, 0, 0, 0, 0, 0, 0));

        // Random part, one setting per phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            if (p == 1) begin
                c = '0;
                program_regs(c);
            end else if (p == 2) begin
                c.swipe_top_band       = 10'd1023;
                c.swipe_min_down       = 10'd1023;
                c.swipe_max_sideways   = 10'd1023;
                c.swipe_abort_up       = 10'd1023;
                c.swipe_abort_sideways = 10'd1023;
                c.pinch_min_dist_sq    = '1;
                c.pinch_step_limit     = 3'd7;
                program_regs(c);
            end else if (p > 2) begin
                program_regs(random_cfg());
            end
            in_mode  = in_modes[p];
            out_mode = out_modes[p];
            c.pinch_step_limit = 3'd0;
            while (sent_count < 25 + (p + 1) * ITEMS_PER_PHASE)
                random_burst();
        end

        wait_drained();
        repeat (10) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: touch_pinch_and_swipe_gesture_top.f
+incdir+src
src/tpsg_pkg.sv
src/tpsg_cfg_regs.sv
src/tpsg_in_stage.sv
src/tpsg_core.sv
src/touch_pinch_and_swipe_gesture_top.sv
src/tpsg_checker.sv
tb/tb_top.sv
